### hw/rtl/bash_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bash_pkg
// Types, widths and constants shared by the bearing and sector hit pipeline.
// ---------------------------------------------------------------------------
package bash_pkg;

    // Field widths
    localparam int C_COORD_W     = 11;
    localparam int C_FRAC        = 6;
    localparam int C_SWEEP_W     = 15;
    localparam int C_BEAR_W      = 15;
    localparam int C_WIN_W       = 12;
    localparam int C_CORDIC_STAGES = 16;
    localparam int C_TAB_LEN     = 24;

    // CORDIC datapath: operands scaled by 2^24, angle in 2^-20 degree
    localparam int C_GUARD       = 24;
    localparam int C_ZSHIFT      = 20;
    localparam int C_VEC_W       = C_COORD_W + C_GUARD + 4;
    localparam int C_ZW          = 29;

    // Angle constants
    localparam logic [C_ZW-1:0] C_ZMAX = C_ZW'(90 << C_ZSHIFT);
    localparam int C_RSH         = C_ZSHIFT - C_FRAC;
    localparam logic [C_ZW-1:0] C_RND  = C_ZW'(1 << (C_RSH - 1));
    localparam logic [C_BEAR_W:0] C_FULL = (C_BEAR_W + 1)'(360 << C_FRAC);
    localparam logic [C_BEAR_W:0] C_HALF = (C_BEAR_W + 1)'(180 << C_FRAC);

    // Window reset, about 3.1 degrees
    localparam logic [C_WIN_W-1:0] C_HALF_WINDOW_RST = C_WIN_W'(198);

    // atan(2^-i) in 2^-20 degree, rounded to nearest
    localparam logic [C_ZW-1:0] C_ATAN_TAB [C_TAB_LEN] = '{
        29'd47185920, 29'd27855475, 29'd14718068, 29'd7471121,
        29'd3750058,  29'd1876857,  29'd938658,   29'd469357,
        29'd234682,   29'd117342,   29'd58671,    29'd29335,
        29'd14668,    29'd7334,     29'd3667,     29'd1833,
        29'd917,      29'd458,      29'd229,      29'd115,
        29'd57,       29'd29,       29'd14,       29'd7
    };

    typedef struct packed {
        logic [C_COORD_W-1:0] origin_x;
        logic [C_COORD_W-1:0] origin_y;
        logic [C_COORD_W-1:0] target_x;
        logic [C_COORD_W-1:0] target_y;
        logic [C_SWEEP_W-1:0] sweep_angle;
    } t_in;

    typedef struct packed {
        logic [C_BEAR_W-1:0] bearing;
        logic                hit;
        logic                zero_vector;
    } t_out;

    // Item context carried alongside the CORDIC
    typedef struct packed {
        logic                 neg_x;
        logic                 neg_y;
        logic                 zero;
        logic [C_SWEEP_W-1:0] sweep;
    } t_ctx;

    typedef struct packed {
        t_ctx                    ctx;
        logic signed [C_VEC_W-1:0] x;
        logic signed [C_VEC_W-1:0] y;
        logic signed [C_ZW-1:0]    z;
    } t_pipe;

endpackage : bash_pkg
`default_nettype wire

### hw/rtl/bash_prep.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bash_prep
// Input stage: forms the difference vector, folds it into the first quadrant
// and loads the CORDIC operands.
// ---------------------------------------------------------------------------
module bash_prep
    import bash_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_in   i_data,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_pipe      o_data
);

    logic                       r_valid;
    t_pipe                      r_data;
    t_pipe                      n_data;
    logic signed [C_COORD_W:0]  dx;
    logic signed [C_COORD_W:0]  dy;
    logic signed [C_COORD_W:0]  adx;
    logic signed [C_COORD_W:0]  ady;

    // Stage advances when empty or when the next stage takes its item
    assign o_ready = !r_valid || i_ready;

    // Difference and magnitude
    always_comb begin
        dx  = signed'({1'b0, i_data.origin_x}) - signed'({1'b0, i_data.target_x});
        dy  = signed'({1'b0, i_data.origin_y}) - signed'({1'b0, i_data.target_y});
        adx = dx[C_COORD_W] ? -dx : dx;
        ady = dy[C_COORD_W] ? -dy : dy;

        n_data.ctx.neg_x = dx[C_COORD_W];
        n_data.ctx.neg_y = dy[C_COORD_W];
        n_data.ctx.zero  = (dx == '0) && (dy == '0);
        n_data.ctx.sweep = i_data.sweep_angle;
        n_data.x = {{(C_VEC_W - C_COORD_W - C_GUARD){1'b0}},
                    ady[C_COORD_W-1:0], {C_GUARD{1'b0}}};
        n_data.y = {{(C_VEC_W - C_COORD_W - C_GUARD){1'b0}},
                    adx[C_COORD_W-1:0], {C_GUARD{1'b0}}};
        n_data.z = '0;
    end

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule : bash_prep
`default_nettype wire

### hw/rtl/bash_cordic_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bash_cordic_stage
// One registered vectoring CORDIC iteration with a fixed shift.
// ---------------------------------------------------------------------------
module bash_cordic_stage
    import bash_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_pipe i_data,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_pipe      o_data
);

    logic                      r_valid;
    t_pipe                     r_data;
    t_pipe                     n_data;
    logic signed [C_VEC_W-1:0] xs;
    logic signed [C_VEC_W-1:0] ys;

    assign o_ready = !r_valid || i_ready;

    // Rotate toward the x axis; both updates use the old x and y
    always_comb begin
        xs = i_data.x >>> STAGE;
        ys = i_data.y >>> STAGE;
        n_data.ctx = i_data.ctx;
        if (!i_data.y[C_VEC_W-1]) begin
            n_data.x = i_data.x + ys;
            n_data.y = i_data.y - xs;
            n_data.z = i_data.z + signed'(C_ATAN_TAB[STAGE]);
        end else begin
            n_data.x = i_data.x - ys;
            n_data.y = i_data.y + xs;
            n_data.z = i_data.z - signed'(C_ATAN_TAB[STAGE]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule : bash_cordic_stage
`default_nettype wire

### hw/rtl/bash_post.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bash_post
// Two output stages: clamp and round the CORDIC angle, then place it in its
// quadrant and test it against the sweep window.
// ---------------------------------------------------------------------------
module bash_post
    import bash_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [C_WIN_W-1:0]  i_half_window,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire t_pipe               i_data,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output t_out                     o_data
);

    // Round stage
    logic                  r_valid_rnd;
    t_ctx                  r_ctx;
    logic [C_BEAR_W-1:0]   r_theta;
    logic [C_BEAR_W-1:0]   n_theta;
    logic [C_ZW-1:0]       z_clamp;
    logic [C_ZW-1:0]       z_round;
    logic                  en_rnd;

    // Output stage
    logic                  r_valid_out;
    t_out                  r_out;
    t_out                  n_out;
    logic [C_BEAR_W:0]     bear;
    logic [C_BEAR_W+1:0]   lo_sum;
    logic [C_BEAR_W+1:0]   hi_sum;
    logic                  en_out;

    assign en_out  = !r_valid_out || i_ready;
    assign en_rnd  = !r_valid_rnd || en_out;
    assign o_ready = en_rnd;

    // Clamp to [0, 90 degrees], round half up
    always_comb begin
        if (i_data.z[C_ZW-1]) begin
            z_clamp = '0;
        end else if (unsigned'(i_data.z) > C_ZMAX) begin
            z_clamp = C_ZMAX;
        end else begin
            z_clamp = unsigned'(i_data.z);
        end
        z_round = (z_clamp + C_RND) >> C_RSH;
        n_theta = z_round[C_BEAR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_rnd <= 1'b0;
        end else if (en_rnd) begin
            r_valid_rnd <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_rnd && i_valid) begin
            r_ctx   <= i_data.ctx;
            r_theta <= n_theta;
        end
    end

    // Quadrant placement, full-turn wrap and window test
    always_comb begin
        unique case ({r_ctx.neg_x, r_ctx.neg_y})
            2'b00:   bear = {1'b0, r_theta};
            2'b01:   bear = C_HALF - {1'b0, r_theta};
            2'b11:   bear = C_HALF + {1'b0, r_theta};
            default: bear = C_FULL - {1'b0, r_theta};
        endcase
        if (bear >= C_FULL) begin
            bear = '0;
        end
        lo_sum = {2'b00, r_ctx.sweep} + (C_BEAR_W + 2)'(i_half_window);
        hi_sum = {1'b0, bear} + (C_BEAR_W + 2)'(i_half_window);

        if (r_ctx.zero) begin
            n_out.bearing     = '0;
            n_out.hit         = 1'b0;
            n_out.zero_vector = 1'b1;
        end else begin
            n_out.bearing     = bear[C_BEAR_W-1:0];
            n_out.hit         = (lo_sum > {1'b0, bear}) &&
                                ({2'b00, r_ctx.sweep} < hi_sum);
            n_out.zero_vector = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_out <= 1'b0;
        end else if (en_out) begin
            r_valid_out <= r_valid_rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_valid_rnd) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid_out;
    assign o_data  = r_out;

endmodule : bash_post
`default_nettype wire

### hw/rtl/bearing_angle_sector_hit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bearing_angle_sector_hit
// Compass bearing of a point pair and sweep-window hit test.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready, i_data) carries origin, target and the
//   sweep angle. Output channel (o_valid / i_ready, o_data) returns the
//   bearing in 1/64 degree, the hit flag and the zero-vector flag, one result
//   per transfer, in input order.
//   The half-window register is written through i_cfg_we / i_cfg_data, by
//   the user only while the pipeline is empty; the block does not enforce
//   this. It resets to 198 (about 3.1 degrees). Stages: one input stage,
//   one per CORDIC iteration, a round stage and the output register.
//   Throughput is one transfer per cycle while the receiver keeps up; every
//   stage holds its own valid bit, so bubbles collapse and the input keeps
//   accepting while a result waits at the output, until every stage is full.
//   Reset (synchronous, active low) empties all stages. A stalled receiver
//   holds the output result steady and backs up the stages behind it.
// ---------------------------------------------------------------------------
module bearing_angle_sector_hit
    import bash_pkg::*;
#(
    parameter int CORDIC_STAGES = C_CORDIC_STAGES
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [C_WIN_W-1:0] i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire t_in                i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output t_out                    o_data
);

    localparam int N = (CORDIC_STAGES < C_TAB_LEN) ? CORDIC_STAGES : C_TAB_LEN;

    logic [C_WIN_W-1:0] r_half_window;
    logic               s_valid [N+1];
    logic               s_ready [N+1];
    t_pipe              s_data  [N+1];

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_window <= C_HALF_WINDOW_RST;
        end else if (i_cfg_we) begin
            r_half_window <= i_cfg_data;
        end
    end

    bash_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (s_valid[0]),
        .i_ready (s_ready[0]),
        .o_data  (s_data[0])
    );

    // CORDIC iterations, one register stage each
    for (genvar k = 0; k < N; k++) begin : g_cordic
        bash_cordic_stage #(
            .STAGE (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .o_ready (s_ready[k]),
            .i_data  (s_data[k]),
            .o_valid (s_valid[k+1]),
            .i_ready (s_ready[k+1]),
            .o_data  (s_data[k+1])
        );
    end

    bash_post u_post (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_half_window (r_half_window),
        .i_valid       (s_valid[N]),
        .o_ready       (s_ready[N]),
        .i_data        (s_data[N]),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_data        (o_data)
    );

endmodule : bearing_angle_sector_hit
`default_nettype wire

### hw/rtl/bash_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bash_checker
// Port-level checks for the bearing pipeline, bound to the top level.
// ---------------------------------------------------------------------------
module bash_checker
    import bash_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_ready,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire t_out o_data
);

    // A stalled result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output result changed while stalled");

    // Input back-pressure only when a result is waiting at the output
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled while output free");

    // Zero vector gives bearing zero and no hit
    a_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.zero_vector |-> o_data.bearing == '0 && !o_data.hit)
        else $error("zero vector result not cleared");

    // Bearing stays below a full turn
    a_bear_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> {1'b0, o_data.bearing} < C_FULL)
        else $error("bearing out of range");

    // Pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

endmodule : bash_checker

bind bearing_angle_sector_hit bash_checker u_bash_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
`default_nettype wire

### sim/tb_bearing_angle_sector_hit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_bearing_angle_sector_hit
// Drives point pairs and sweep angles into the bearing pipeline. Each
// transfer is checked against a bit-accurate CORDIC bearing predictor, with
// random idle cycles on both channels and several half-window settings.
// ---------------------------------------------------------------------------
module tb_bearing_angle_sector_hit
    import bash_pkg::*;
();

    localparam int     CORDIC_ITERS = 16;
    localparam longint DEG180       = 180 * 64;
    localparam longint DEG360       = 360 * 64;
    localparam longint Z_MAX        = 64'sd90 <<< 20;
    localparam longint Z_ROUND      = 64'sd1 <<< 13;
    localparam int     IDLE_PCT     = 14;
    localparam int     DRAIN_CYCLES = 40;

    // atan(2^-i) in 2^-20 degree
    localparam longint ATAN_STEP [CORDIC_ITERS] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [C_WIN_W-1:0]   i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    t_in                  i_data;
    logic                 o_valid;
    logic                 i_ready;
    t_out                 o_data;

    logic [C_WIN_W-1:0]   half_window;
    bit                   calm;
    int                   err_count;
    t_out                 pending_bearings[$];

    bearing_angle_sector_hit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Overall limit on run length
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Vectoring CORDIC: angle of (ax, ay) from the y axis, in 1/64 degree
    function automatic longint cordic_theta(longint ax, longint ay);
        longint x, y, z, xs, ys;
        x = ay <<< 24;
        y = ax <<< 24;
        z = 0;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_STEP[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_STEP[i];
            end
        end
        if (z < 0) z = 0;
        if (z > Z_MAX) z = Z_MAX;
        return (z + Z_ROUND) >>> 14;
    endfunction

    // Expected bearing, hit and zero flag for one point pair
    function automatic t_out predict_bearing(t_in p, logic [C_WIN_W-1:0] w);
        longint ox, oy, tx, ty, dx, dy, sw, wl, th, b;
        t_out   r;
        ox = longint'(p.origin_x);
        oy = longint'(p.origin_y);
        tx = longint'(p.target_x);
        ty = longint'(p.target_y);
        sw = longint'(p.sweep_angle);
        wl = longint'(w);
        dx = ox - tx;
        dy = oy - ty;
        r  = '0;
        b  = 0;
        if (dx == 0 && dy == 0) begin
            r.zero_vector = 1'b1;
        end else begin
            th = cordic_theta(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
            if (dx >= 0) b = (dy >= 0) ? th : DEG180 - th;
            else         b = (dy < 0) ? DEG180 + th : DEG360 - th;
            // a bearing that rounds to a full turn wraps to zero
            if (b >= DEG360) b = 0;
            r.hit = (sw + wl > b) && (sw < b + wl);
        end
        r.bearing = b[C_BEAR_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        err_count++;
        $display("%0t: %s mismatch: got %0d, expected %0d", $time, field, got, want);
    endtask

    // Receiver: stall at random unless in a calm stretch
    always @(negedge i_clk) begin
        i_ready = calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_bearings.size() == 0) begin
                report_mismatch("unexpected result, bearing",
                                longint'(o_data.bearing), -1);
            end else begin
                want = pending_bearings.pop_front();
                if (o_data.bearing !== want.bearing)
                    report_mismatch("bearing", longint'(o_data.bearing),
                                    longint'(want.bearing));
                if (o_data.hit !== want.hit)
                    report_mismatch("hit", longint'(o_data.hit), longint'(want.hit));
                if (o_data.zero_vector !== want.zero_vector)
                    report_mismatch("zero_vector", longint'(o_data.zero_vector),
                                    longint'(want.zero_vector));
            end
        end
    end

    // Offer one item, idling at random first; return after its transfer
    task automatic send_point(t_in item);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data  = item;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_bearings.push_back(predict_bearing(item, half_window));
    endtask

    task automatic send_pair(int ox, int oy, int tx, int ty, int sweep);
        t_in item;
        item.origin_x    = ox[C_COORD_W-1:0];
        item.origin_y    = oy[C_COORD_W-1:0];
        item.target_x    = tx[C_COORD_W-1:0];
        item.target_y    = ty[C_COORD_W-1:0];
        item.sweep_angle = sweep[C_SWEEP_W-1:0];
        send_point(item);
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic drain_pipeline();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_bearings.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_half_window(logic [C_WIN_W-1:0] value);
        drain_pipeline();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        half_window = value;
    endtask

    // Origin equal to target, at both corners of the grid
    task automatic test_zero_vector();
        send_pair(0, 0, 0, 0, 0);
        send_pair(2047, 2047, 2047, 2047, 0);
    endtask

    // Four axes and the four extreme diagonals
    task automatic test_axes_and_diagonals();
        send_pair(1024, 2047, 1024, 0, 0);
        send_pair(2047, 1024, 0, 1024, 90 * 64);
        send_pair(1024, 0, 1024, 2047, 180 * 64);
        send_pair(0, 1024, 2047, 1024, 270 * 64);
        send_pair(2047, 2047, 0, 0, 45 * 64);
        send_pair(2047, 0, 0, 2047, 135 * 64);
        send_pair(0, 0, 2047, 2047, 225 * 64);
        send_pair(0, 2047, 2047, 0, 315 * 64);
    endtask

    // Bearings just short of a full turn
    task automatic test_near_full_turn();
        send_pair(0, 2047, 1, 0, 23039);
        send_pair(999, 1000, 1000, 0, 0);
    endtask

    // Sweep at the bearing and on both edges of the open window
    task automatic test_window_edges();
        t_in  probe;
        t_out probe_res;
        int   b, w;
        probe = '{origin_x: 1500, origin_y: 900, target_x: 300, target_y: 200,
                  sweep_angle: 0};
        probe_res = predict_bearing(probe, half_window);
        b = int'(probe_res.bearing);
        w = int'(half_window);
        send_pair(1500, 900, 300, 200, b);
        send_pair(1500, 900, 300, 200, b + w - 1);
        send_pair(1500, 900, 300, 200, b + w);
        send_pair(1500, 900, 300, 200, b - w + 1);
        send_pair(1500, 900, 300, 200, b - w);
    endtask

    // Sweep at zero, at a full turn and at the top of its field
    task automatic test_sweep_range();
        send_pair(2047, 1024, 0, 1024, 0);
        send_pair(2047, 1024, 0, 1024, 23040);
        send_pair(2047, 1024, 0, 1024, 32767);
    endtask

    // Zero, near or full-range pairs; sweeps near the bearing or anywhere
    task automatic make_random_item(output t_in item);
        int   mode, ox, oy, tx, ty, s, off, b;
        t_out guess;
        mode = $urandom_range(0, 99);
        tx = $urandom_range(0, 2047);
        ty = $urandom_range(0, 2047);
        if (mode < 5) begin
            ox = tx;
            oy = ty;
        end else if (mode < 45) begin
            ox = tx + int'($urandom_range(0, 16)) - 8;
            oy = ty + int'($urandom_range(0, 16)) - 8;
            if (ox < 0 || ox > 2047) ox = 2 * tx - ox;
            if (oy < 0 || oy > 2047) oy = 2 * ty - oy;
        end else begin
            ox = $urandom_range(0, 2047);
            oy = $urandom_range(0, 2047);
        end
        item.origin_x    = ox[C_COORD_W-1:0];
        item.origin_y    = oy[C_COORD_W-1:0];
        item.target_x    = tx[C_COORD_W-1:0];
        item.target_y    = ty[C_COORD_W-1:0];
        item.sweep_angle = '0;
        mode = $urandom_range(0, 99);
        if (mode < 50) begin
            guess = predict_bearing(item, half_window);
            b   = int'(guess.bearing);
            off = $urandom_range(0, 2 * int'(half_window) + 4);
            s   = b + off - int'(half_window) - 2;
            if (s < 0) s = 0;
            if (s > 32767) s = 32767;
        end else if (mode < 60) begin
            s = $urandom_range(0, 32767);
        end else begin
            s = $urandom_range(0, 23040);
        end
        item.sweep_angle = s[C_SWEEP_W-1:0];
    endtask

    task automatic run_random(int count);
        t_in item;
        for (int n = 0; n < count; n++) begin
            make_random_item(item);
            send_point(item);
            // now and then hold the sender until the pipeline has emptied
            if ($urandom_range(0, 99) == 0) drain_pipeline();
        end
    endtask

    task automatic test_random_reset_window();
        run_random(230);
    endtask

    task automatic test_random_window_extremes();
        write_half_window('0);
        run_random(150);
        write_half_window({C_WIN_W{1'b1}});
        run_random(150);
        write_half_window(C_WIN_W'(2880));
        run_random(150);
        write_half_window(C_WIN_W'(1));
        run_random(150);
        write_half_window(C_WIN_W'($urandom_range(0, 4095)));
        run_random(150);
    endtask

    // Back to the reset width with no idling on either side
    task automatic test_calm_stretch();
        write_half_window(C_HALF_WINDOW_RST);
        calm = 1'b1;
        run_random(150);
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_ready     = 1'b0;
        calm        = 1'b0;
        err_count   = 0;
        half_window = C_HALF_WINDOW_RST;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_zero_vector();
        test_axes_and_diagonals();
        test_near_full_turn();
        test_window_edges();
        test_sweep_range();
        test_random_reset_window();
        test_random_window_extremes();
        test_calm_stretch();

        // Let any stray result show up before the verdict
        drain_pipeline();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
